// ----- hw/rtl/epcal_pkg.sv -----
// shared constants, types and calendar helpers for the epoch seconds converter
package epcal_pkg;

  localparam int unsigned SecsW  = 32;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned TodW   = 17;
  localparam int unsigned YearW  = 8;
  localparam int unsigned YdayW  = 9;

  localparam logic [7:0] YearBase = 8'd70;  // 1970 minus 1900

  // reciprocal constants: floor(x / d) == (x * M) >> K over the stated x range
  localparam logic [25:0] RecipDay  = 26'd50903317;  // (secs >> 7) / 675, K 35
  localparam logic [13:0] RecipHour = 14'd9321;      // (tod >> 4) / 225, K 21
  localparam logic [10:0] RecipMin  = 11'd1093;      // (rem >> 2) / 15, K 14
  localparam logic [18:0] RecipYear = 19'd367469;    // (4 * days) / 1461, K 29
  localparam logic [16:0] RecipWeek = 17'd74899;     // x / 7, K 19

  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin  = 6'd60;
  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [7:0]  Year2100    = 8'd130;  // 2100 is not a leap year

  typedef struct packed {
    logic [YearW-1:0] years_since_1900;
    logic [3:0]       month;
    logic [4:0]       month_day;
    logic [YdayW-1:0] year_day;
  } ymd_t;

  // leap rule over 1970..2106, index counts years from 1970
  function automatic logic is_leap(input logic [YearW-1:0] idx);
    is_leap = (idx[1:0] == 2'b10) && (idx != Year2100);
  endfunction

  // day number of january 1 of year 1970 + idx
  function automatic logic [DaysW-1:0] year_start(input logic [YearW-1:0] idx);
    logic [16:0] base;
    logic [YearW-1:0] nxt;
    nxt  = idx + 8'd1;
    base = 17'(idx) * 17'(DaysPerYear) + 17'(nxt[YearW-1:2]);
    if (idx > Year2100) begin
      base = base - 17'd1;
    end
    year_start = base[DaysW-1:0];
  endfunction

  // first day of month within the year
  function automatic logic [YdayW-1:0] month_start(input logic [3:0] mon, input logic leap);
    logic [YdayW-1:0] cum;
    case (mon)
      4'd0:    cum = 9'd0;
      4'd1:    cum = 9'd31;
      4'd2:    cum = 9'd59;
      4'd3:    cum = 9'd90;
      4'd4:    cum = 9'd120;
      4'd5:    cum = 9'd151;
      4'd6:    cum = 9'd181;
      4'd7:    cum = 9'd212;
      4'd8:    cum = 9'd243;
      4'd9:    cum = 9'd273;
      4'd10:   cum = 9'd304;
      4'd11:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    if (leap && (mon >= 4'd2)) begin
      cum = cum + 9'd1;
    end
    month_start = cum;
  endfunction

endpackage

// ----- hw/rtl/epcal_ymd.sv -----
// date pipeline: day count to year, month, day of month and day of year
module epcal_ymd (
  input  logic                              clk_i,
  input  logic [epcal_pkg::DaysW-1:0]       days_i,
  output epcal_pkg::ymd_t                   ymd_o
);
  import epcal_pkg::*;

  // stage a: year estimate product
  logic [36:0]       yprod_q, yprod_d;
  logic [DaysW-1:0]  days_a_q;

  // stage b: corrected year index and its start day
  logic [YearW-1:0]  est_b;
  logic [YearW-1:0]  est_nxt_b;
  logic [DaysW-1:0]  start_nxt_b;
  logic              ge_b;
  logic [YearW-1:0]  idx_b_q, idx_b_d;
  logic [DaysW-1:0]  base_b_q, base_b_d;
  logic [DaysW-1:0]  days_b_q;

  // stage c: day of year
  logic [DaysW-1:0]  yday_full_c;
  logic [YdayW-1:0]  yday_c_q;
  logic [YearW-1:0]  idx_c_q;
  logic              leap_c_q;

  // stage d: month split
  logic [3:0]        mon_d;
  logic [YdayW-1:0]  mday_full_d;
  ymd_t              ymd_q, ymd_d;

  assign yprod_d = 37'({days_i, 2'b00}) * 37'(RecipYear);

  always_ff @(posedge clk_i) begin
    yprod_q  <= yprod_d;
    days_a_q <= days_i;
  end

  // estimate is the true year or one below it
  always_comb begin
    est_b       = yprod_q[36:29];
    est_nxt_b   = est_b + 8'd1;
    start_nxt_b = year_start(est_nxt_b);
    ge_b        = (days_a_q >= start_nxt_b);
    idx_b_d     = ge_b ? est_nxt_b : est_b;
    base_b_d    = ge_b ? start_nxt_b : year_start(est_b);
  end

  always_ff @(posedge clk_i) begin
    idx_b_q  <= idx_b_d;
    base_b_q <= base_b_d;
    days_b_q <= days_a_q;
  end

  assign yday_full_c = days_b_q - base_b_q;

  always_ff @(posedge clk_i) begin
    yday_c_q <= yday_full_c[YdayW-1:0];
    idx_c_q  <= idx_b_q;
    leap_c_q <= is_leap(idx_b_q);
  end

  always_comb begin
    mon_d = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (yday_c_q >= month_start(4'(m), leap_c_q)) begin
        mon_d = 4'(m);
      end
    end
    mday_full_d             = yday_c_q - month_start(mon_d, leap_c_q) + 9'd1;
    ymd_d.years_since_1900  = idx_c_q + YearBase;
    ymd_d.month             = mon_d;
    ymd_d.month_day         = mday_full_d[4:0];
    ymd_d.year_day          = yday_c_q;
  end

  always_ff @(posedge clk_i) begin
    ymd_q <= ymd_d;
  end

  assign ymd_o = ymd_q;

endmodule

// ----- hw/rtl/epoch_seconds_to_utc_calendar_core.sv -----
// Epoch seconds to UTC calendar: a six-stage pipeline takes one conversion per cycle on start_i,
// busy_o stays low, and each result appears on done_o as its start leaves the last stage; the
// depth comes from the chain of reciprocal multiplies (days, hours, minutes, year estimate), each
// followed by a register, and results cannot be held off by the receiver.
module epoch_seconds_to_utc_calendar_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [epcal_pkg::SecsW-1:0]        epoch_seconds_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [5:0]                         second_o,
  output logic [5:0]                         minute_o,
  output logic [4:0]                         hour_o,
  output logic [2:0]                         weekday_o,
  output logic [7:0]                         years_since_1900_o,
  output logic [3:0]                         month_o,
  output logic [4:0]                         month_day_o,
  output logic [8:0]                         year_day_o
);
  import epcal_pkg::*;

  localparam int unsigned Depth = 6;

  logic [Depth-1:0] vld_q, vld_d;

  // stage 1: day quotient product
  logic [50:0]      dprod_q, dprod_d;
  logic [SecsW-1:0] secs_q;

  // stage 2: days and time of day
  logic [DaysW-1:0] days2_d, days2_q;
  logic [32:0]      dsec2;
  logic [TodW-1:0]  tod2_d, tod2_q;

  // stage 3: hour and weekday products
  logic [26:0]      hprod_q, hprod_d;
  logic [32:0]      wprod_q, wprod_d;
  logic [DaysW-1:0] wx3_d, wx3_q;
  logic [TodW-1:0]  tod3_q;

  // stage 4: hour, remainder, weekday
  logic [4:0]       hr4_d, hr4_q;
  logic [16:0]      hsec4;
  logic [11:0]      rem4_d, rem4_q;
  logic [13:0]      wq4;
  logic [2:0]       wday4_d, wday4_q;

  // stage 5: minute product
  logic [20:0]      mprod_q, mprod_d;
  logic [11:0]      rem5_q;
  logic [4:0]       hr5_q;
  logic [2:0]       wday5_q;

  // stage 6: outputs
  logic [5:0]       min6_d;
  logic [11:0]      msec6;
  logic [5:0]       sec6_d;
  logic [5:0]       sec_q, min_q;
  logic [4:0]       hr_q;
  logic [2:0]       wday_q;
  ymd_t             ymd;

  // no backpressure on the result side, so a transaction is never refused
  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[Depth-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign dprod_d = 51'(epoch_seconds_i[SecsW-1:7]) * 51'(RecipDay);

  always_ff @(posedge clk_i) begin
    dprod_q <= dprod_d;
    secs_q  <= epoch_seconds_i;
  end

  always_comb begin
    days2_d = dprod_q[50:35];
    dsec2   = 33'(days2_d) * 33'(SecsPerDay);
    tod2_d  = secs_q[TodW-1:0] - dsec2[TodW-1:0];
  end

  always_ff @(posedge clk_i) begin
    days2_q <= days2_d;
    tod2_q  <= tod2_d;
  end

  // 1970-01-01 was a thursday
  assign wx3_d   = days2_q + 16'd4;
  assign hprod_d = 27'(tod2_q[TodW-1:4]) * 27'(RecipHour);
  assign wprod_d = 33'(wx3_d) * 33'(RecipWeek);

  always_ff @(posedge clk_i) begin
    hprod_q <= hprod_d;
    wprod_q <= wprod_d;
    wx3_q   <= wx3_d;
    tod3_q  <= tod2_q;
  end

  always_comb begin
    hr4_d   = hprod_q[25:21];
    hsec4   = 17'(hr4_d) * 17'(SecsPerHour);
    rem4_d  = tod3_q[11:0] - hsec4[11:0];
    wq4     = wprod_q[32:19];
    // true remainder is below 7, so three bits carry it exactly
    wday4_d = wx3_q[2:0] - (wq4[2:0] * 3'd7);
  end

  always_ff @(posedge clk_i) begin
    hr4_q   <= hr4_d;
    rem4_q  <= rem4_d;
    wday4_q <= wday4_d;
  end

  assign mprod_d = 21'(rem4_q[11:2]) * 21'(RecipMin);

  always_ff @(posedge clk_i) begin
    mprod_q <= mprod_d;
    rem5_q  <= rem4_q;
    hr5_q   <= hr4_q;
    wday5_q <= wday4_q;
  end

  always_comb begin
    min6_d = mprod_q[19:14];
    msec6  = 12'(min6_d) * 12'(SecsPerMin);
    sec6_d = rem5_q[5:0] - msec6[5:0];
  end

  always_ff @(posedge clk_i) begin
    sec_q  <= sec6_d;
    min_q  <= min6_d;
    hr_q   <= hr5_q;
    wday_q <= wday5_q;
  end

  epcal_ymd u_ymd (
    .clk_i  (clk_i),
    .days_i (days2_q),
    .ymd_o  (ymd)
  );

  assign done_o             = vld_q[Depth-1];
  assign second_o           = sec_q;
  assign minute_o           = min_q;
  assign hour_o             = hr_q;
  assign weekday_o          = wday_q;
  assign years_since_1900_o = ymd.years_since_1900;
  assign month_o            = ymd.month;
  assign month_day_o        = ymd.month_day;
  assign year_day_o         = ymd.year_day;

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Depth))
    else $error("result strobe without a start six cycles earlier");

  a_start_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##6 done_o)
    else $error("accepted transaction produced no result");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hour_o < 5'd24) && (minute_o < 6'd60) && (second_o < 6'd60)
               && (weekday_o < 3'd7))
    else $error("time of day or weekday out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_o < 4'd12) && (month_day_o != 5'd0) && (year_day_o < 9'd366)
               && (years_since_1900_o >= 8'd70) && (years_since_1900_o <= 8'd206))
    else $error("calendar date out of range");

endmodule
